FILE: src/ryw_pkg.sv
// ----------------------------------------------------------------------------
// ryw_pkg: shared types and constants of the RGB to YUV 4:2:0 plane writer
// Payload structs, register map, Q16 color matrix constants and the
// fixed-point saturation helper.
// ----------------------------------------------------------------------------
package ryw_pkg;

	// frame geometry limits
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COUNT_W    = $clog2(MAX_WIDTH);
	localparam int ROWCNT_W   = $clog2(MAX_HEIGHT);
	localparam int SIZE_W     = 13;
	localparam int STRIDE_W   = 14;
	localparam int STEP_W     = 3;
	localparam int OFFSET_W   = 26;
	localparam int PIX_W      = 8;

	// widths that follow from the limits
	localparam logic [SIZE_W-1:0] WIDTH_LIMIT   = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] HEIGHT_LIMIT  = SIZE_W'(MAX_HEIGHT);
	localparam logic [SIZE_W-1:0] BT601_MAX_COL = SIZE_W'(720);

	// configuration port
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GRAY_INPUT        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LUMA_STRIDE       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CHROMA_ROW_STRIDE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CHROMA_PIXEL_STEP = 3'd5;

	// Q16 matrix coefficients, magnitudes; signs are fixed per output
	localparam int COEF_W = 16;
	localparam logic [COEF_W-1:0] Y601_R  = 16'd16843;
	localparam logic [COEF_W-1:0] Y601_G  = 16'd33030;
	localparam logic [COEF_W-1:0] Y601_B  = 16'd6423;
	localparam logic [COEF_W-1:0] Y709_R  = 16'd11993;
	localparam logic [COEF_W-1:0] Y709_G  = 16'd40239;
	localparam logic [COEF_W-1:0] Y709_B  = 16'd4063;
	localparam logic [COEF_W-1:0] CB601_R = 16'd9699;
	localparam logic [COEF_W-1:0] CB601_G = 16'd19071;
	localparam logic [COEF_W-1:0] CB709_R = 16'd6619;
	localparam logic [COEF_W-1:0] CB709_G = 16'd22217;
	localparam logic [COEF_W-1:0] C_MAIN  = 16'd28770;
	localparam logic [COEF_W-1:0] CR601_G = 16'd24117;
	localparam logic [COEF_W-1:0] CR601_B = 16'd4653;
	localparam logic [COEF_W-1:0] CR709_G = 16'd26149;
	localparam logic [COEF_W-1:0] CR709_B = 16'd2621;

	// accumulator geometry
	localparam int FRAC_W = 16;
	localparam int PROD_W = PIX_W + COEF_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam logic [ACC_W-1:0] Y_BIAS = ACC_W'(16) << FRAC_W;
	localparam logic [ACC_W-1:0] C_BIAS = ACC_W'(128) << FRAC_W;

	// queue depths
	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	typedef struct packed {
		logic [PIX_W-1:0] red_or_gray;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]    luma;
		logic [OFFSET_W-1:0] luma_offset;
		logic                chroma_valid;
		logic [PIX_W-1:0]    blue_diff;
		logic [PIX_W-1:0]    red_diff;
		logic [OFFSET_W-1:0] chroma_offset;
		logic                frame_last;
	} pix_out_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   image_width;
		logic [SIZE_W-1:0]   image_height;
		logic                gray_input;
		logic [STRIDE_W-1:0] luma_stride;
		logic [STRIDE_W-1:0] chroma_row_stride;
		logic [STEP_W-1:0]   chroma_pixel_step;
	} cfg_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic [PIX_W-1:0]    red;
		logic [PIX_W-1:0]    green;
		logic [PIX_W-1:0]    blue;
		logic [COUNT_W-1:0]  column;
		logic [ROWCNT_W-1:0] row;
		logic                chroma;
		logic                bt601;
		logic                frame_last;
	} mid_entry_t;

	// floor a Q16 sum and clamp it to 0..255
	function automatic logic [PIX_W-1:0] sat_q16(input logic [ACC_W-1:0] acc);
		logic [PIX_W-1:0] res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (|acc[ACC_W-2:FRAC_W+PIX_W]) begin
			res = '1;
		end else begin
			res = acc[FRAC_W+PIX_W-1:FRAC_W];
		end
		return res;
	endfunction

endpackage

FILE: src/ryw_cfg.sv
// ----------------------------------------------------------------------------
// ryw_cfg: configuration register file
// APB-style register block holding frame size, input mode and plane strides.
// ----------------------------------------------------------------------------
module ryw_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ryw_pkg::ADDR_W-1:0] paddr,
	input  logic [ryw_pkg::DATA_W-1:0] pwdata,
	output logic [ryw_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output ryw_pkg::cfg_t              cfg
);
	import ryw_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width       <= SIZE_W'(720);
			cfg_q.image_height      <= SIZE_W'(576);
			cfg_q.gray_input        <= 1'b0;
			cfg_q.luma_stride       <= STRIDE_W'(720);
			cfg_q.chroma_row_stride <= STRIDE_W'(360);
			cfg_q.chroma_pixel_step <= STEP_W'(1);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:       cfg_q.image_width       <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:      cfg_q.image_height      <= pwdata[SIZE_W-1:0];
				REG_GRAY_INPUT:        cfg_q.gray_input        <= pwdata[0];
				REG_LUMA_STRIDE:       cfg_q.luma_stride       <= pwdata[STRIDE_W-1:0];
				REG_CHROMA_ROW_STRIDE: cfg_q.chroma_row_stride <= pwdata[STRIDE_W-1:0];
				REG_CHROMA_PIXEL_STEP: cfg_q.chroma_pixel_step <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_IMAGE_WIDTH:       prdata = DATA_W'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:      prdata = DATA_W'(cfg_q.image_height);
			REG_GRAY_INPUT:        prdata = DATA_W'(cfg_q.gray_input);
			REG_LUMA_STRIDE:       prdata = DATA_W'(cfg_q.luma_stride);
			REG_CHROMA_ROW_STRIDE: prdata = DATA_W'(cfg_q.chroma_row_stride);
			REG_CHROMA_PIXEL_STEP: prdata = DATA_W'(cfg_q.chroma_pixel_step);
			default:               prdata = '0;
		endcase
	end

endmodule

FILE: src/ryw_front.sv
// ----------------------------------------------------------------------------
// ryw_front: pixel intake and classification
// Tracks column and row, picks the color matrix, flags chroma sites and the
// end of frame, and queues the classified pixel for the arithmetic back end.
// ----------------------------------------------------------------------------
module ryw_front (
	input  logic                clk,
	input  logic                arst_n,
	input  ryw_pkg::cfg_t       cfg,
	input  logic                push,
	input  ryw_pkg::pix_in_t    pixel,
	output logic                full,
	output logic                mid_valid,
	output ryw_pkg::mid_entry_t mid_entry,
	input  logic                mid_take
);
	import ryw_pkg::*;

	logic [COUNT_W-1:0]  col_q;
	logic [ROWCNT_W-1:0] row_q;
	logic [SIZE_W-1:0]   width_eff;
	logic [SIZE_W-1:0]   height_eff;
	logic                row_end;
	logic                frame_end;
	logic                accept;
	mid_entry_t          entry;

	mid_entry_t          mem_q [MID_DEPTH];
	logic [MID_PTR_W-1:0] wr_ptr_q;
	logic [MID_PTR_W-1:0] rd_ptr_q;
	logic [MID_PTR_W:0]   cnt_q;

	// effective frame size, clamped to the supported range
	always_comb begin
		if (cfg.image_width == '0) begin
			width_eff = SIZE_W'(1);
		end else if (cfg.image_width > WIDTH_LIMIT) begin
			width_eff = WIDTH_LIMIT;
		end else begin
			width_eff = cfg.image_width;
		end
		if (cfg.image_height == '0) begin
			height_eff = SIZE_W'(1);
		end else if (cfg.image_height > HEIGHT_LIMIT) begin
			height_eff = HEIGHT_LIMIT;
		end else begin
			height_eff = cfg.image_height;
		end
	end

	// position flags
	assign row_end   = (SIZE_W'(col_q) + SIZE_W'(1)) >= width_eff;
	assign frame_end = row_end && ((SIZE_W'(row_q) + SIZE_W'(1)) >= height_eff);
	assign accept    = push && !full;

	// classify the incoming pixel
	always_comb begin
		entry.red        = pixel.red_or_gray;
		entry.green      = cfg.gray_input ? pixel.red_or_gray : pixel.green;
		entry.blue       = cfg.gray_input ? pixel.red_or_gray : pixel.blue;
		entry.column     = col_q;
		entry.row        = row_q;
		entry.chroma     = !col_q[0] && !row_q[0];
		entry.bt601      = width_eff <= BT601_MAX_COL;
		entry.frame_last = frame_end;
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + ROWCNT_W'(1);
			end else begin
				col_q <= col_q + COUNT_W'(1);
			end
		end
	end

	// queue between front and back
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + MID_PTR_W'(1);
			end
			if (mid_take) begin
				rd_ptr_q <= rd_ptr_q + MID_PTR_W'(1);
			end
			if (accept && !mid_take) begin
				cnt_q <= cnt_q + (MID_PTR_W+1)'(1);
			end else if (!accept && mid_take) begin
				cnt_q <= cnt_q - (MID_PTR_W+1)'(1);
			end
		end
	end

	assign full      = cnt_q == (MID_PTR_W+1)'(MID_DEPTH);
	assign mid_valid = cnt_q != '0;
	assign mid_entry = mem_q[rd_ptr_q];

endmodule

FILE: src/ryw_back.sv
// ----------------------------------------------------------------------------
// ryw_back: color matrix and plane offsets
// Multiplies in one stage, sums, floors and clamps into the result queue.
// Issue from the front queue is credit based on free result slots.
// ----------------------------------------------------------------------------
module ryw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ryw_pkg::cfg_t       cfg,
	input  logic                mid_valid,
	input  ryw_pkg::mid_entry_t mid_entry,
	output logic                mid_take,
	input  logic                pop,
	output logic                empty,
	output ryw_pkg::pix_out_t   result
);
	import ryw_pkg::*;

	localparam int CCOL_W = COUNT_W - 1 + STEP_W;

	// selected coefficients
	logic [COEF_W-1:0] cy_r, cy_g, cy_b, ccb_r, ccb_g, ccr_g, ccr_b;

	// multiply stage
	logic                  v_s1;
	logic [PROD_W-1:0]     y_r_s1, y_g_s1, y_b_s1;
	logic [PROD_W-1:0]     cb_r_s1, cb_g_s1, cb_b_s1;
	logic [PROD_W-1:0]     cr_r_s1, cr_g_s1, cr_b_s1;
	logic [OFFSET_W-1:0]   loff_s1;
	logic [COUNT_W-1:0]    col_s1;
	logic [OFFSET_W-1:0]   crow_s1;
	logic [CCOL_W-1:0]     ccol_s1;
	logic                  chroma_s1;
	logic                  last_s1;

	// sums
	logic [ACC_W-1:0] acc_y, acc_cb, acc_cr;
	pix_out_t         res;

	// result queue
	pix_out_t             out_mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] out_wr_q;
	logic [OUT_PTR_W-1:0] out_rd_q;
	logic [OUT_PTR_W:0]   out_cnt_q;
	logic [OUT_PTR_W:0]   in_use;
	logic                 out_pop;

	// issue only when a result slot is certain to be free
	assign in_use   = out_cnt_q + (OUT_PTR_W+1)'(v_s1);
	assign mid_take = mid_valid && (in_use < (OUT_PTR_W+1)'(OUT_DEPTH));

	// matrix select
	always_comb begin
		if (mid_entry.bt601) begin
			cy_r  = Y601_R;
			cy_g  = Y601_G;
			cy_b  = Y601_B;
			ccb_r = CB601_R;
			ccb_g = CB601_G;
			ccr_g = CR601_G;
			ccr_b = CR601_B;
		end else begin
			cy_r  = Y709_R;
			cy_g  = Y709_G;
			cy_b  = Y709_B;
			ccb_r = CB709_R;
			ccb_g = CB709_G;
			ccr_g = CR709_G;
			ccr_b = CR709_B;
		end
	end

	// multiply stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= mid_take;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_take) begin
			y_r_s1    <= PROD_W'(mid_entry.red)   * PROD_W'(cy_r);
			y_g_s1    <= PROD_W'(mid_entry.green) * PROD_W'(cy_g);
			y_b_s1    <= PROD_W'(mid_entry.blue)  * PROD_W'(cy_b);
			cb_r_s1   <= PROD_W'(mid_entry.red)   * PROD_W'(ccb_r);
			cb_g_s1   <= PROD_W'(mid_entry.green) * PROD_W'(ccb_g);
			cb_b_s1   <= PROD_W'(mid_entry.blue)  * PROD_W'(C_MAIN);
			cr_r_s1   <= PROD_W'(mid_entry.red)   * PROD_W'(C_MAIN);
			cr_g_s1   <= PROD_W'(mid_entry.green) * PROD_W'(ccr_g);
			cr_b_s1   <= PROD_W'(mid_entry.blue)  * PROD_W'(ccr_b);
			loff_s1   <= OFFSET_W'(mid_entry.row) * OFFSET_W'(cfg.luma_stride);
			col_s1    <= mid_entry.column;
			crow_s1   <= OFFSET_W'(mid_entry.row[ROWCNT_W-1:1])
				* OFFSET_W'(cfg.chroma_row_stride);
			ccol_s1   <= CCOL_W'(mid_entry.column[COUNT_W-1:1])
				* CCOL_W'(cfg.chroma_pixel_step);
			chroma_s1 <= mid_entry.chroma;
			last_s1   <= mid_entry.frame_last;
		end
	end

	// sum, floor and clamp
	assign acc_y  = Y_BIAS + ACC_W'(y_r_s1) + ACC_W'(y_g_s1) + ACC_W'(y_b_s1);
	assign acc_cb = C_BIAS + ACC_W'(cb_b_s1) - ACC_W'(cb_r_s1) - ACC_W'(cb_g_s1);
	assign acc_cr = C_BIAS + ACC_W'(cr_r_s1) - ACC_W'(cr_g_s1) - ACC_W'(cr_b_s1);

	always_comb begin
		res.luma          = sat_q16(acc_y);
		res.luma_offset   = loff_s1 + OFFSET_W'(col_s1);
		res.chroma_valid  = chroma_s1;
		res.blue_diff     = chroma_s1 ? sat_q16(acc_cb) : '0;
		res.red_diff      = chroma_s1 ? sat_q16(acc_cr) : '0;
		res.chroma_offset = chroma_s1 ? (crow_s1 + OFFSET_W'(ccol_s1)) : '0;
		res.frame_last    = last_s1;
	end

	// result queue
	assign out_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (v_s1) begin
				out_wr_q <= out_wr_q + OUT_PTR_W'(1);
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + OUT_PTR_W'(1);
			end
			if (v_s1 && !out_pop) begin
				out_cnt_q <= out_cnt_q + (OUT_PTR_W+1)'(1);
			end else if (!v_s1 && out_pop) begin
				out_cnt_q <= out_cnt_q - (OUT_PTR_W+1)'(1);
			end
		end
	end

	assign empty  = out_cnt_q == '0;
	assign result = out_mem_q[out_rd_q];

endmodule

FILE: src/rgb_to_yuv420_plane_writer_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_plane_writer_unit: RGB to Y'CbCr 4:2:0 plane writer
// Converts raster pixels to limited-range luma for every pixel and Cb/Cr on
// even rows and columns, with byte offsets into the luma and chroma planes.
//
//   channel   direction   handshake             payload
//   pixel     in          push / full           pix_in_t  (r or gray, g, b)
//   result    out         pop / empty           pix_out_t (Y, Cb, Cr, offsets)
//   config    in          psel/penable/pready   32-bit registers at 4*index
//
// One pixel per clock sustained while pops keep up; a request reaches the
// result ports via the front queue, one multiply stage, result queue write.
// Issue into the multiply stage is bounded by free slots in the four-entry
// result queue, so pops that stall back up into the four-entry front queue.
// Reset clears counters, queue pointers and registers; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_plane_writer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ryw_pkg::ADDR_W-1:0] paddr,
	input  logic [ryw_pkg::DATA_W-1:0] pwdata,
	output logic [ryw_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       push,
	input  ryw_pkg::pix_in_t           pixel,
	output logic                       full,
	input  logic                       pop,
	output logic                       empty,
	output ryw_pkg::pix_out_t          result
);
	import ryw_pkg::*;

	cfg_t       cfg;
	logic       mid_valid;
	mid_entry_t mid_entry;
	logic       mid_take;

	// register file
	ryw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// intake and classification
	ryw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.mid_valid (mid_valid),
		.mid_entry (mid_entry),
		.mid_take  (mid_take)
	);

	// arithmetic and result queue
	ryw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid_entry (mid_entry),
		.mid_take  (mid_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

`ifndef SYNTHESIS
	// back end never draws from an empty front queue
	assert property (@(posedge clk) disable iff (!arst_n) mid_take |-> mid_valid)
		else $error("back end took a request from an empty front queue");

	// non-chroma sites carry zero chroma fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.chroma_valid) |->
		(result.blue_diff == '0 && result.red_diff == '0 && result.chroma_offset == '0))
		else $error("chroma fields set on a non-chroma site");

	// limited-range luma stays within 16..235
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.luma >= 8'd16 && result.luma <= 8'd235))
		else $error("luma outside limited range");

	// a request taken by the back end reaches the result queue via the multiply stage register
	assert property (@(posedge clk) disable iff (!arst_n)
		mid_take |=> ##1 !empty)
		else $error("issued request did not reach the result queue");
`endif

endmodule

FILE: tb/tb_rgb_to_yuv420_plane_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv420_plane_writer_unit: self-checking bench for the plane writer
// Pushes raster pixels through the block under several frame geometries,
// color modes and strides. A scoreboard class mirrors the block's column and
// row counters and its Q16 color matrices to predict each Y/Cb/Cr request, and
// compares every popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rgb_to_yuv420_plane_writer_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ryw_pkg::*;

	localparam int     STALL_LIMIT = 5000;
	localparam int     HOLD_CYCLES = 60;
	localparam int     IDLE_PCT    = 13;
	localparam int     MAX_REPORTS = 10;
	localparam longint Q_ONE       = 65536;

	// Q16 matrix, round(c * 65536)
	localparam longint KY601_R  = 16843;
	localparam longint KY601_G  = 33030;
	localparam longint KY601_B  = 6423;
	localparam longint KY709_R  = 11993;
	localparam longint KY709_G  = 40239;
	localparam longint KY709_B  = 4063;
	localparam longint KCB601_R = -9699;
	localparam longint KCB601_G = -19071;
	localparam longint KCB709_R = -6619;
	localparam longint KCB709_G = -22217;
	localparam longint KC_MAIN  = 28770;
	localparam longint KCR601_G = -24117;
	localparam longint KCR601_B = -4653;
	localparam longint KCR709_G = -26149;
	localparam longint KCR709_B = -2621;

	// predicts Y/Cb/Cr samples and plane offsets, holds them until popped
	class yuv_plane_checker;
		logic [SIZE_W-1:0]   width_reg;
		logic [SIZE_W-1:0]   height_reg;
		logic                gray_reg;
		logic [STRIDE_W-1:0] luma_stride_reg;
		logic [STRIDE_W-1:0] chroma_stride_reg;
		logic [STEP_W-1:0]   step_reg;
		int                  column;
		int                  row;
		pix_out_t            pending_samples[$];
		int                  mismatch_count;

		function new();
			width_reg         = 13'd720;
			height_reg        = 13'd576;
			gray_reg          = 1'b0;
			luma_stride_reg   = 14'd720;
			chroma_stride_reg = 14'd360;
			step_reg          = 3'd1;
			column            = 0;
			row               = 0;
			mismatch_count    = 0;
		endfunction

		function void write_field(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH:       width_reg         = val[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:      height_reg        = val[SIZE_W-1:0];
				REG_GRAY_INPUT:        gray_reg          = val[0];
				REG_LUMA_STRIDE:       luma_stride_reg   = val[STRIDE_W-1:0];
				REG_CHROMA_ROW_STRIDE: chroma_stride_reg = val[STRIDE_W-1:0];
				REG_CHROMA_PIXEL_STEP: step_reg          = val[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		// exact dot product plus bias, floored and clamped to a byte
		function logic [PIX_W-1:0] q16_sample(input longint kr, input longint kg,
				input longint kb, input longint bias, input int r, input int g, input int b);
			longint acc;
			acc = kr * r + kg * g + kb * b + bias * Q_ONE;
			if (acc < 0)
				return '0;
			if (acc > 255 * Q_ONE + 65535)
				return '1;
			return PIX_W'(acc >>> 16);
		endfunction

		function void take_pixel(input pix_in_t px);
			int       w;
			int       h;
			int       r;
			int       g;
			int       b;
			bit       bt601;
			bit       chroma;
			bit       row_end;
			bit       frame_end;
			pix_out_t want;
			w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
			h = (height_reg == 0) ? 1 :
				((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
			bt601     = (w <= 720);
			chroma    = (row[0] == 1'b0) && (column[0] == 1'b0);
			row_end   = (column + 1 >= w);
			frame_end = row_end && (row + 1 >= h);
			r = px.red_or_gray;
			g = gray_reg ? r : int'(px.green);
			b = gray_reg ? r : int'(px.blue);

			want = '0;
			if (bt601)
				want.luma = q16_sample(KY601_R, KY601_G, KY601_B, 16, r, g, b);
			else
				want.luma = q16_sample(KY709_R, KY709_G, KY709_B, 16, r, g, b);
			want.luma_offset  = OFFSET_W'(longint'(row) * luma_stride_reg + column);
			want.chroma_valid = chroma;
			// chroma only on even rows and columns, zero elsewhere
			if (chroma) begin
				if (bt601) begin
					want.blue_diff = q16_sample(KCB601_R, KCB601_G, KC_MAIN, 128, r, g, b);
					want.red_diff  = q16_sample(KC_MAIN, KCR601_G, KCR601_B, 128, r, g, b);
				end else begin
					want.blue_diff = q16_sample(KCB709_R, KCB709_G, KC_MAIN, 128, r, g, b);
					want.red_diff  = q16_sample(KC_MAIN, KCR709_G, KCR709_B, 128, r, g, b);
				end
				want.chroma_offset = OFFSET_W'(longint'(row >> 1) * chroma_stride_reg
					+ longint'(column >> 1) * step_reg);
			end
			want.frame_last = frame_end;
			pending_samples.push_back(want);

			// raster position
			if (frame_end) begin
				column = 0;
				row    = 0;
			end else if (row_end) begin
				column = 0;
				row++;
			end else begin
				column++;
			end
		endfunction

		function void check_sample(input pix_out_t got);
			pix_out_t want;
			bit       bad;
			if (pending_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result with nothing pending: Y=%0d yoff=%0d",
						got.luma, got.luma_offset);
				return;
			end
			want = pending_samples.pop_front();
			bad = (got.luma !== want.luma) || (got.luma_offset !== want.luma_offset)
				|| (got.chroma_valid !== want.chroma_valid)
				|| (got.blue_diff !== want.blue_diff) || (got.red_diff !== want.red_diff)
				|| (got.chroma_offset !== want.chroma_offset)
				|| (got.frame_last !== want.frame_last);
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("mismatch: exp Y=%0d yoff=%0d cv=%0b cb=%0d cr=%0d coff=%0d last=%0b",
						want.luma, want.luma_offset, want.chroma_valid, want.blue_diff,
						want.red_diff, want.chroma_offset, want.frame_last,
						" | got Y=%0d yoff=%0d cv=%0b cb=%0d cr=%0d coff=%0d last=%0b",
						got.luma, got.luma_offset, got.chroma_valid, got.blue_diff,
						got.red_diff, got.chroma_offset, got.frame_last);
			end
		endfunction

		function int outstanding();
			return pending_samples.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                push;
	pix_in_t             pixel;
	logic                full;
	logic                pop;
	logic                empty;
	pix_out_t            result;

	yuv_plane_checker    sb = new();
	int                  pixels_sent;
	int                  results_seen;
	bit                  hold_off_req;

	rgb_to_yuv420_plane_writer_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.pixel   (pixel),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// register write: setup cycle, then access until pready
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_field(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering pixels and let every pending request come back
	task automatic wait_drain();
		push <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_geometry(input int w, input int h, input int gray,
			input int ls, input int cs, input int step);
		wait_drain();
		write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
		write_reg(REG_IMAGE_HEIGHT, DATA_W'(h));
		write_reg(REG_GRAY_INPUT, DATA_W'(gray));
		write_reg(REG_LUMA_STRIDE, DATA_W'(ls));
		write_reg(REG_CHROMA_ROW_STRIDE, DATA_W'(cs));
		write_reg(REG_CHROMA_PIXEL_STEP, DATA_W'(step));
	endtask

	// one pixel request, with random idle cycles ahead of it
	task automatic send_pixel(input pix_in_t px);
		while (!(pixels_sent >= 500 && pixels_sent < 700) && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (full);
		sb.take_pixel(px);
		pixels_sent++;
	endtask

	// component value biased toward the extremes
	function automatic logic [PIX_W-1:0] rand_level();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	// stimulus
	initial begin
		pix_in_t corners [8];
		int      w;
		int      h;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		push         = 1'b0;
		pixel        = '0;
		pixels_sent  = 0;
		hold_off_req = 1'b0;
		for (int i = 0; i < 8; i++)
			corners[i] = {i[2] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, i[0] ? 8'hFF : 8'h00};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// color cube corners with reset geometry, BT.601
		foreach (corners[i])
			send_pixel(corners[i]);
		// same corners just above the BT.601 width, widest strides and step
		program_geometry(721, 2, 1'b0, 16383, 16383, 7);
		foreach (corners[i])
			send_pixel(corners[i]);
		// zero size clamps to 1x1, gray mode, zero strides and step
		program_geometry(0, 0, 1'b1, 0, 0, 0);
		send_pixel({8'h00, rand_level(), rand_level()});
		send_pixel({8'hFF, rand_level(), rand_level()});
		send_pixel({8'h80, rand_level(), rand_level()});
		send_pixel({8'h4D, rand_level(), rand_level()});
		// oversize clamps to the maximum frame
		program_geometry(8191, 8191, 1'b0, 1, 1, 4);
		repeat (4) send_pixel({rand_level(), rand_level(), rand_level()});

		// random phases
		for (int ph = 0; ph < 11; ph++) begin
			case (ph)
				0: program_geometry(720, 3, 0, $urandom_range(16383), $urandom_range(16383),
					$urandom_range(7));
				1: program_geometry(721, 2, 1, $urandom_range(16383), $urandom_range(16383),
					$urandom_range(7));
				2: program_geometry(1, 8191, 0, 16383, 16383, 7);
				3: begin
					program_geometry(5, 4, 0, 5, 3, 2);
					hold_off_req = 1'b1;
				end
				default: begin
					w = ($urandom_range(9) < 7) ? $urandom_range(9, 1) :
						(($urandom_range(1) != 0) ? $urandom_range(740, 700) :
						$urandom_range(8191));
					h = ($urandom_range(9) < 7) ? $urandom_range(6, 1) : $urandom_range(8191);
					program_geometry(w, h, $urandom_range(1), $urandom_range(16383),
						$urandom_range(16383), $urandom_range(7));
				end
			endcase
			repeat (100) send_pixel({rand_level(), rand_level(), rand_level()});
		end

		// drain and settle
		wait_drain();
		repeat (20) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// result side: random pops, one long hold-off on request
	initial begin
		int hold_left;
		bit want_pop;
		pop          = 1'b0;
		hold_left    = 0;
		results_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_left    = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				want_pop = 1'b0;
			end else if (results_seen >= 500 && results_seen < 700) begin
				want_pop = 1'b1;
			end else begin
				want_pop = ($urandom_range(99) >= IDLE_PCT);
			end
			pop <= want_pop;
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_sample(result);
				results_seen++;
			end
		end
	end

	// watchdog on cycles without any accepted request
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
src/ryw_pkg.sv
src/ryw_cfg.sv
src/ryw_front.sv
src/ryw_back.sv
src/rgb_to_yuv420_plane_writer_unit.sv
tb/tb_rgb_to_yuv420_plane_writer_unit.sv
